FILE: rtl/core/chs_pkg.sv
// ----------------------------------------------------------------------------
// chs_pkg - convex hull store shared definitions
// Action codes carried by the input item of the hull store.
// ----------------------------------------------------------------------------
package chs_pkg;

    localparam int ACTION_W = 3;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ADD      = 3'd0,
        ACT_REMOVE   = 3'd1,
        ACT_CLEAR    = 3'd2,
        ACT_CENTROID = 3'd3,
        ACT_READ     = 3'd4
    } action_t;

endpackage

FILE: rtl/core/incremental_convex_hull_store.sv
// ----------------------------------------------------------------------------
// incremental_convex_hull_store - convex hull vertex store
// Keeps hull vertices, rebuilds the hull on add, serves remove, clear,
// centroid and vertex read requests.
// ----------------------------------------------------------------------------
// One item is handled at a time under a small sequencer; s_ready is high only
// while the sequencer is idle, and a finished result waits in the output
// register so the next item can be taken while it is pending. With n stored
// vertices an add copies the store, insertion-sorts the n+1 points (one
// sort-memory read per compare), runs cross-product tests of the chain (one
// shared multiplier used twice per test) and writes back the new hull of m
// vertices; the sort dominates its cost. Remove scans and shifts the store,
// and a centroid query sums the n vertices, then runs two passes of a
// one-bit-per-cycle divider over a COORD_BITS+$clog2(MAX_VERTICES+1)+4 bit
// dividend. No clearing pass follows reset: the stores are only read below the
// vertex count.
// ----------------------------------------------------------------------------
module incremental_convex_hull_store #(
    parameter int MAX_VERTICES = 64,
    parameter int COORD_BITS   = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // request channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [chs_pkg::ACTION_W-1:0]        s_action,
    input  logic signed [COORD_BITS-1:0]        s_x_coord,
    input  logic signed [COORD_BITS-1:0]        s_y_coord,
    input  logic [$clog2(MAX_VERTICES)-1:0]     s_vertex_index,
    // result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_ok_flag,
    output logic                                m_overflow_flag,
    output logic [$clog2(MAX_VERTICES+1)-1:0]   m_vertex_total,
    output logic signed [COORD_BITS-1:0]        m_vertex_x,
    output logic signed [COORD_BITS-1:0]        m_vertex_y,
    output logic signed [COORD_BITS+3:0]        m_centroid_x,
    output logic signed [COORD_BITS+3:0]        m_centroid_y
);
    import chs_pkg::*;

    localparam int CB    = COORD_BITS;
    localparam int PW    = 2 * CB;                       // packed point {x, y}
    localparam int VI    = $clog2(MAX_VERTICES);         // hull index
    localparam int CW    = $clog2(MAX_VERTICES + 1);     // vertex count
    localparam int NPTS  = MAX_VERTICES + 1;
    localparam int SI    = $clog2(NPTS);                 // sort index
    localparam int IW    = $clog2(MAX_VERTICES + 2);     // loop counters
    localparam int NSCR  = 2 * NPTS;
    localparam int KI    = $clog2(NSCR);                 // scratch index
    localparam int KW    = KI + 1;                       // chain depth
    localparam int DW_   = CB + 1;                       // coordinate difference
    localparam int MW    = 2 * DW_;                      // product
    localparam int SUMW  = CB + CW;                      // coordinate sum
    localparam int DIVW  = SUMW + 4;                     // scaled dividend
    localparam int DCW   = $clog2(DIVW + 1);
    localparam int OW    = CB + 4;                       // Q4 result

    typedef enum logic [4:0] {
        S_IDLE, S_HC_RD, S_HC_WR, S_HC_P,
        S_SRT_RD, S_SRT_LD, S_SRT_CMP, S_SRT_JW,
        S_CH_RD, S_CH_LD, S_TR_RD, S_TR_DIF, S_TR_M1, S_TR_M2, S_TR_CMP, S_PUSH,
        S_CM_CHK, S_CM_RD, S_CM_WR,
        S_RM_RD, S_RM_CHK, S_RM_SRD, S_RM_SWR,
        S_SUM_RD, S_SUM_ACC, S_DIV_LD, S_DIV, S_DIV_END,
        S_VR_RD, S_VR_LD, S_DONE
    } state_t;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t                 state_reg;
    logic [PW-1:0]          pt_reg;          // request point {x, y}
    logic [VI-1:0]          idx_reg;
    logic [CW-1:0]          count_reg;
    logic [IW-1:0]          n1_reg;          // points taking part in the rebuild
    logic [IW-1:0]          i_reg;
    logic [IW-1:0]          j_reg;
    logic [KW-1:0]          k_reg;
    logic [KW-1:0]          klim_reg;
    logic [KW-1:0]          m_reg;
    logic                   upper_reg;
    logic [PW-1:0]          cand_reg;
    logic signed [DW_-1:0]  dax_reg, day_reg, dbx_reg, dby_reg;
    logic signed [MW-1:0]   p1_reg, p2_reg;
    logic signed [SUMW-1:0] sumx_reg, sumy_reg;
    logic                   ysel_reg;
    logic                   neg_reg;
    logic [DIVW-1:0]        dq_reg;
    logic [CW-1:0]          rem_reg;
    logic [DCW-1:0]         dcnt_reg;
    logic                   res_ok_reg, res_ovf_reg;
    logic [PW-1:0]          res_v_reg;
    logic signed [OW-1:0]   res_cx_reg, res_cy_reg;

    // ------------------------------------------------------------------
    // Memories: hull store, sort buffer, chain scratch
    // ------------------------------------------------------------------
    logic [PW-1:0] hull_mem [MAX_VERTICES];
    logic [PW-1:0] sort_mem [NPTS];
    logic [PW-1:0] scr_mem  [NSCR];

    logic [PW-1:0] hull_rd_reg, sort_rd_reg, scr_a_rd_reg, scr_b_rd_reg;

    logic          hull_we;
    logic [VI-1:0] hull_waddr, hull_raddr;
    logic [PW-1:0] hull_wdata;
    logic          sort_we;
    logic [SI-1:0] sort_waddr, sort_raddr;
    logic [PW-1:0] sort_wdata;
    logic          scr_we;
    logic [KI-1:0] scr_waddr, scr_a_addr, scr_b_addr;

    logic [IW-1:0] i_inc;
    logic [IW-1:0] j_dec;
    logic [KW-1:0] k_m1, k_m2;

    assign i_inc = i_reg + 1'b1;
    assign j_dec = j_reg - 1'b1;
    assign k_m1  = k_reg - 1'b1;
    assign k_m2  = k_reg - 2'd2;

    // x above y in a packed point
    function automatic logic signed [CB-1:0] px_of(input logic [PW-1:0] p);
        px_of = p[PW-1:CB];
    endfunction

    function automatic logic signed [CB-1:0] py_of(input logic [PW-1:0] p);
        py_of = p[CB-1:0];
    endfunction

    function automatic logic lex_less(input logic [PW-1:0] a, input logic [PW-1:0] b);
        lex_less = (px_of(a) < px_of(b)) || ((px_of(a) == px_of(b)) && (py_of(a) < py_of(b)));
    endfunction

    // sort compare: the held candidate against the entry below slot j
    logic cand_less;
    assign cand_less = lex_less(cand_reg, sort_rd_reg);

    always_comb begin
        hull_raddr = i_reg[VI-1:0];
        if (state_reg == S_VR_RD) begin
            hull_raddr = idx_reg;
        end else if (state_reg == S_RM_SRD) begin
            hull_raddr = i_inc[VI-1:0];
        end
        hull_we    = (state_reg == S_CM_WR) || (state_reg == S_RM_SWR);
        hull_waddr = i_reg[VI-1:0];
        hull_wdata = (state_reg == S_CM_WR) ? scr_a_rd_reg : hull_rd_reg;
    end

    always_comb begin
        sort_raddr = (state_reg == S_SRT_CMP) ? j_dec[SI-1:0] : i_reg[SI-1:0];
        sort_we    = 1'b0;
        sort_waddr = i_reg[SI-1:0];
        sort_wdata = hull_rd_reg;
        case (state_reg)
            S_HC_WR: begin
                sort_we = 1'b1;
            end
            S_HC_P: begin
                sort_we    = 1'b1;
                sort_waddr = SI'(count_reg);
                sort_wdata = pt_reg;
            end
            S_SRT_CMP: begin
                sort_we    = (j_reg == '0);
                sort_waddr = '0;
                sort_wdata = cand_reg;
            end
            S_SRT_JW: begin
                sort_we    = 1'b1;
                sort_waddr = j_reg[SI-1:0];
                sort_wdata = cand_less ? sort_rd_reg : cand_reg;
            end
            default: begin
                sort_we = 1'b0;
            end
        endcase
    end

    always_comb begin
        scr_a_addr = (state_reg == S_CM_RD) ? KI'(i_reg) : k_m2[KI-1:0];
        scr_b_addr = k_m1[KI-1:0];
        scr_we     = (state_reg == S_PUSH);
        scr_waddr  = k_reg[KI-1:0];
    end

    always_ff @(posedge aclk) begin
        if (hull_we) begin
            hull_mem[hull_waddr] <= hull_wdata;
        end
        hull_rd_reg <= hull_mem[hull_raddr];
    end

    always_ff @(posedge aclk) begin
        if (sort_we) begin
            sort_mem[sort_waddr] <= sort_wdata;
        end
        sort_rd_reg <= sort_mem[sort_raddr];
    end

    always_ff @(posedge aclk) begin
        if (scr_we) begin
            scr_mem[scr_waddr] <= cand_reg;
        end
        scr_a_rd_reg <= scr_mem[scr_a_addr];
        scr_b_rd_reg <= scr_mem[scr_b_addr];
    end

    // ------------------------------------------------------------------
    // Shared multiplier for the cross product: two products per test
    // ------------------------------------------------------------------
    logic signed [DW_-1:0] mul_a, mul_b;
    logic signed [MW-1:0]  mul_res;

    assign mul_a   = (state_reg == S_TR_M1) ? dax_reg : day_reg;
    assign mul_b   = (state_reg == S_TR_M1) ? dby_reg : dbx_reg;
    assign mul_res = mul_a * mul_b;

    // ------------------------------------------------------------------
    // Restoring divider step for the centroid, one quotient bit a cycle
    // ------------------------------------------------------------------
    logic [CW:0]             rem_sh;
    logic                    rem_ge;
    logic [CW:0]             rem_sub;
    logic signed [SUMW-1:0]  sum_sel;
    logic signed [DIVW-1:0]  sum_scaled;
    logic [DIVW-1:0]         sum_mag;
    logic signed [OW-1:0]    quo;

    assign rem_sh     = {rem_reg, dq_reg[DIVW-1]};
    assign rem_ge     = (rem_sh >= {1'b0, count_reg});
    assign rem_sub    = rem_sh - {1'b0, count_reg};
    assign sum_sel    = ysel_reg ? sumy_reg : sumx_reg;
    assign sum_scaled = DIVW'(sum_sel) <<< 4;
    assign sum_mag    = sum_scaled[DIVW-1] ? DIVW'(-sum_scaled) : DIVW'(sum_scaled);
    assign quo        = neg_reg ? -$signed(dq_reg[OW-1:0]) : $signed(dq_reg[OW-1:0]);

    logic signed [CB:0] o_x, o_y, a_x, a_y, c_x, c_y;
    assign o_x = DW_'(px_of(scr_a_rd_reg));
    assign o_y = DW_'(py_of(scr_a_rd_reg));
    assign a_x = DW_'(px_of(scr_b_rd_reg));
    assign a_y = DW_'(py_of(scr_b_rd_reg));
    assign c_x = DW_'(px_of(cand_reg));
    assign c_y = DW_'(py_of(cand_reg));

    assign s_ready = (state_reg == S_IDLE);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            m_valid   <= 1'b0;
        end else begin
            // drop a taken result; the handoff below covers S_DONE itself
            if (m_valid && m_ready && (state_reg != S_DONE)) begin
                m_valid <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        pt_reg      <= {s_x_coord, s_y_coord};
                        idx_reg     <= s_vertex_index;
                        res_ok_reg  <= 1'b0;
                        res_ovf_reg <= 1'b0;
                        res_v_reg   <= '0;
                        res_cx_reg  <= '0;
                        res_cy_reg  <= '0;
                        i_reg       <= '0;
                        case (s_action)
                            ACT_ADD: begin
                                n1_reg    <= IW'(count_reg) + 1'b1;
                                state_reg <= S_HC_RD;
                            end
                            ACT_REMOVE: begin
                                state_reg <= S_RM_RD;
                            end
                            ACT_CLEAR: begin
                                count_reg  <= '0;
                                res_ok_reg <= 1'b1;
                                state_reg  <= S_DONE;
                            end
                            ACT_CENTROID: begin
                                res_ok_reg <= 1'b1;
                                sumx_reg   <= '0;
                                sumy_reg   <= '0;
                                ysel_reg   <= 1'b0;
                                state_reg  <= (count_reg == '0) ? S_DONE : S_SUM_RD;
                            end
                            ACT_READ: begin
                                state_reg <= (CW'(s_vertex_index) < count_reg) ? S_VR_RD
                                                                               : S_DONE;
                            end
                            default: begin
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end

                // copy the store into the sort buffer, then append the point
                S_HC_RD: begin
                    state_reg <= (i_reg == IW'(count_reg)) ? S_HC_P : S_HC_WR;
                end
                S_HC_WR: begin
                    i_reg     <= i_inc;
                    state_reg <= S_HC_RD;
                end
                S_HC_P: begin
                    i_reg     <= IW'(1);
                    state_reg <= S_SRT_RD;
                end

                // insertion sort by x, then y
                S_SRT_RD: begin
                    if (i_reg == n1_reg) begin
                        i_reg     <= '0;
                        k_reg     <= '0;
                        klim_reg  <= KW'(2);
                        upper_reg <= 1'b0;
                        state_reg <= S_CH_RD;
                    end else begin
                        state_reg <= S_SRT_LD;
                    end
                end
                S_SRT_LD: begin
                    cand_reg  <= sort_rd_reg;
                    j_reg     <= i_reg;
                    state_reg <= S_SRT_CMP;
                end
                S_SRT_CMP: begin
                    if (j_reg == '0) begin
                        i_reg     <= i_inc;
                        state_reg <= S_SRT_RD;
                    end else begin
                        state_reg <= S_SRT_JW;
                    end
                end
                S_SRT_JW: begin
                    if (cand_less) begin
                        j_reg     <= j_dec;
                        state_reg <= S_SRT_CMP;
                    end else begin
                        i_reg     <= i_inc;
                        state_reg <= S_SRT_RD;
                    end
                end

                // monotone chain: lower pass then upper pass
                S_CH_RD: begin
                    state_reg <= S_CH_LD;
                end
                S_CH_LD: begin
                    cand_reg  <= sort_rd_reg;
                    state_reg <= S_TR_RD;
                end
                S_TR_RD: begin
                    state_reg <= (k_reg >= klim_reg) ? S_TR_DIF : S_PUSH;
                end
                S_TR_DIF: begin
                    dax_reg   <= a_x - o_x;
                    day_reg   <= a_y - o_y;
                    dbx_reg   <= c_x - o_x;
                    dby_reg   <= c_y - o_y;
                    state_reg <= S_TR_M1;
                end
                S_TR_M1: begin
                    p1_reg    <= mul_res;
                    state_reg <= S_TR_M2;
                end
                S_TR_M2: begin
                    p2_reg    <= mul_res;
                    state_reg <= S_TR_CMP;
                end
                S_TR_CMP: begin
                    // pop on a right turn or a straight line
                    if (p1_reg <= p2_reg) begin
                        k_reg     <= k_m1;
                        state_reg <= S_TR_RD;
                    end else begin
                        state_reg <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    k_reg <= k_reg + 1'b1;
                    if (!upper_reg) begin
                        if (i_reg == n1_reg - 1'b1) begin
                            if (n1_reg == IW'(1)) begin
                                m_reg     <= KW'(1);
                                state_reg <= S_CM_CHK;
                            end else begin
                                upper_reg <= 1'b1;
                                klim_reg  <= k_reg + KW'(2);
                                i_reg     <= n1_reg - IW'(2);
                                state_reg <= S_CH_RD;
                            end
                        end else begin
                            i_reg     <= i_inc;
                            state_reg <= S_CH_RD;
                        end
                    end else begin
                        if (i_reg == '0) begin
                            m_reg     <= k_reg;
                            state_reg <= S_CM_CHK;
                        end else begin
                            i_reg     <= i_reg - 1'b1;
                            state_reg <= S_CH_RD;
                        end
                    end
                end

                // refuse an oversize hull, else write it back
                S_CM_CHK: begin
                    i_reg <= '0;
                    if (m_reg > KW'(MAX_VERTICES)) begin
                        res_ovf_reg <= 1'b1;
                        state_reg   <= S_DONE;
                    end else begin
                        state_reg <= S_CM_RD;
                    end
                end
                S_CM_RD: begin
                    if (KW'(i_reg) == m_reg) begin
                        count_reg <= CW'(m_reg);
                        state_reg <= S_DONE;
                    end else begin
                        state_reg <= S_CM_WR;
                    end
                end
                S_CM_WR: begin
                    if (scr_a_rd_reg == pt_reg) begin
                        res_ok_reg <= 1'b1;
                    end
                    i_reg     <= i_inc;
                    state_reg <= S_CM_RD;
                end

                // remove the first matching vertex and close the gap
                S_RM_RD: begin
                    state_reg <= (i_reg == IW'(count_reg)) ? S_DONE : S_RM_CHK;
                end
                S_RM_CHK: begin
                    if (hull_rd_reg == pt_reg) begin
                        state_reg <= S_RM_SRD;
                    end else begin
                        i_reg     <= i_inc;
                        state_reg <= S_RM_RD;
                    end
                end
                S_RM_SRD: begin
                    if (i_inc == IW'(count_reg)) begin
                        count_reg  <= count_reg - 1'b1;
                        res_ok_reg <= 1'b1;
                        state_reg  <= S_DONE;
                    end else begin
                        state_reg <= S_RM_SWR;
                    end
                end
                S_RM_SWR: begin
                    i_reg     <= i_inc;
                    state_reg <= S_RM_SRD;
                end

                // centroid: sum, then divide x and y in turn
                S_SUM_RD: begin
                    state_reg <= (i_reg == IW'(count_reg)) ? S_DIV_LD : S_SUM_ACC;
                end
                S_SUM_ACC: begin
                    sumx_reg  <= sumx_reg + SUMW'(px_of(hull_rd_reg));
                    sumy_reg  <= sumy_reg + SUMW'(py_of(hull_rd_reg));
                    i_reg     <= i_inc;
                    state_reg <= S_SUM_RD;
                end
                S_DIV_LD: begin
                    dq_reg    <= sum_mag;
                    neg_reg   <= sum_scaled[DIVW-1];
                    rem_reg   <= '0;
                    dcnt_reg  <= DCW'(DIVW);
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    rem_reg  <= rem_ge ? rem_sub[CW-1:0] : rem_sh[CW-1:0];
                    dq_reg   <= {dq_reg[DIVW-2:0], rem_ge};
                    dcnt_reg <= dcnt_reg - 1'b1;
                    if (dcnt_reg == DCW'(1)) begin
                        state_reg <= S_DIV_END;
                    end
                end
                S_DIV_END: begin
                    if (!ysel_reg) begin
                        res_cx_reg <= quo;
                        ysel_reg   <= 1'b1;
                        state_reg  <= S_DIV_LD;
                    end else begin
                        res_cy_reg <= quo;
                        state_reg  <= S_DONE;
                    end
                end

                // vertex read
                S_VR_RD: begin
                    state_reg <= S_VR_LD;
                end
                S_VR_LD: begin
                    res_v_reg  <= hull_rd_reg;
                    res_ok_reg <= 1'b1;
                    state_reg  <= S_DONE;
                end

                // hand the result to the output register once it is free
                S_DONE: begin
                    if (!m_valid || m_ready) begin
                        m_valid         <= 1'b1;
                        m_ok_flag       <= res_ok_reg;
                        m_overflow_flag <= res_ovf_reg;
                        m_vertex_total  <= count_reg;
                        m_vertex_x      <= px_of(res_v_reg);
                        m_vertex_y      <= py_of(res_v_reg);
                        m_centroid_x    <= res_cx_reg;
                        m_centroid_y    <= res_cy_reg;
                        state_reg       <= S_IDLE;
                    end
                end

                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_VERTICES))
        else $error("vertex count beyond capacity");

    a_refused_not_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_ok_flag && m_overflow_flag))
        else $error("refused add reported as hull vertex");

    a_chain_in_scratch: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_PUSH) |-> (k_reg < KW'(NSCR)))
        else $error("chain push beyond scratch");

    a_result_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready && (state_reg == S_DONE)) |=> (state_reg == S_DONE))
        else $error("result dropped while output stalled");

endmodule
